### hdl/rtwu_pkg.sv
// Package: types, codes and defaults shared by the retransmit window unit.
package rtwu_pkg;

  localparam int DEF_TABLE_DEPTH = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_APPLIED  = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_RETX     = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  localparam logic REG_INIT_SEQNO  = 1'b0;
  localparam logic REG_INIT_WINDOW = 1'b1;

  localparam logic [15:0] RESET_WINDOW = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] seg_seqno;
    logic [15:0] seg_len;
    logic [31:0] seg_timeout;
    logic [31:0] ack_number;
    logic [15:0] new_window;
    logic [31:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_seqno;
    logic [15:0] out_len;
    logic        last;
    logic [15:0] window_now;
    logic [31:0] in_flight;
    logic        window_full;
    logic [4:0]  entries_used;
  } out_item_t;

  typedef struct packed {
    logic [63:0] start;
    logic [15:0] len;
    logic [31:0] timer;
  } entry_t;

endpackage

### hdl/rtwu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/tcp_retransmit_window_unit.sv
// Top level: TCP retransmit window, sequenced over a simple dual-port segment table.
// An ack that is applied searches the table entry by entry from the tail; a tick
// visits every segment held. Waiting on out_stall can hold an item longer. The
// segment table RAM sets the pace: one entry at a time is read (registered), then
// compared or updated. in_stall stays high while an item is being worked;
// finished results sit in an output register. The table has no reset; only
// entries written by adds are read.
module tcp_retransmit_window_unit #(
  parameter int TABLE_DEPTH = rtwu_pkg::DEF_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtwu_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rtwu_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import rtwu_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UNWRAP   = 4'd1;
  localparam logic [3:0] S_ADD      = 4'd2;
  localparam logic [3:0] S_ACK_CHK  = 4'd3;
  localparam logic [3:0] S_SRCH_RD  = 4'd4;
  localparam logic [3:0] S_SRCH_CMP = 4'd5;
  localparam logic [3:0] S_ACK_UPD  = 4'd6;
  localparam logic [3:0] S_TICK_RD  = 4'd7;
  localparam logic [3:0] S_TICK_CMP = 4'd8;
  localparam logic [3:0] S_TICK_END = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;

  logic [3:0]    state;
  in_item_t      item;
  logic [31:0]   init_seqno;
  logic [63:0]   first_abs;
  logic [63:0]   next_abs;
  logic [15:0]   window_bytes;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [63:0]   abs_seq;
  logic [CW-1:0] k;
  logic [AW-1:0] ptr;
  logic [CW-1:0] pop;
  logic [2:0]    emit_status;
  logic          hold_v;
  logic [31:0]   hold_seq;
  logic [15:0]   hold_len;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        rd;

  rtwu_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ptr),
    .rdata(rd)
  );

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] b, input logic [CW-1:0] n);
    logic [AW:0] s;
    s = (AW+1)'(b) + (AW+1)'(n);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // Status shown with every result
  logic [63:0] flight64;
  logic        full;
  logic [31:0] flight_sat;
  assign flight64   = next_abs - first_abs;
  assign full       = (window_bytes == '0) ||
                      ((count != '0) && (flight64 >= {48'd0, window_bytes}));
  assign flight_sat = (flight64[63:32] != '0) ? '1 : flight64[31:0];

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Unwrap of the wrapped number against next_abs
  logic [31:0] src, off, nlo, nhi, d_up, d_dn, uhi;
  assign src  = (item.opcode == OP_ADD) ? item.seg_seqno : item.ack_number;
  assign off  = src - init_seqno;
  assign nlo  = next_abs[31:0];
  assign nhi  = next_abs[63:32];
  assign d_up = off - nlo;
  assign d_dn = nlo - off;
  always_comb begin
    uhi = nhi;
    if (off > nlo) begin
      if (d_up > 32'h8000_0000 && nhi != '0) begin
        uhi = nhi - 32'd1;
      end
    end else if (d_dn > 32'h8000_0000) begin
      uhi = nhi + 32'd1;
    end
  end

  logic [AW-1:0] tail;
  assign tail = wrap_add(head, count);

  logic        ld;
  logic [2:0]  ld_status;
  logic [31:0] ld_seq;
  logic [15:0] ld_len;
  logic        ld_last;
  logic        reject;
  assign reject = full || (count >= DEPTH_C);

  always_comb begin
    ld        = 1'b0;
    ld_status = emit_status;
    ld_seq    = '0;
    ld_len    = '0;
    ld_last   = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = rd;
    ram_wdata.timer = rd.timer - item.elapsed_ms;
    case (state)
      S_ADD: begin
        if (!reject) begin
          ram_we          = 1'b1;
          ram_waddr       = tail;
          ram_wdata.start = abs_seq;
          ram_wdata.len   = item.seg_len;
          ram_wdata.timer = item.seg_timeout;
        end
      end
      S_SRCH_RD, S_TICK_RD: begin
        ram_re = (state == S_SRCH_RD) || (k != count);
      end
      S_TICK_CMP: begin
        if (rd.timer > item.elapsed_ms) begin
          ram_we = 1'b1;
        end else if (hold_v && out_free) begin
          ld        = 1'b1;
          ld_status = ST_RETX;
          ld_seq    = hold_seq;
          ld_len    = hold_len;
          ld_last   = 1'b0;
        end
      end
      S_TICK_END: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = hold_v ? ST_RETX : ST_NONE;
          ld_seq    = hold_v ? hold_seq : '0;
          ld_len    = hold_v ? hold_len : '0;
        end
      end
      S_EMIT: begin
        ld = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      init_seqno   <= '0;
      first_abs    <= '0;
      next_abs     <= '0;
      window_bytes <= RESET_WINDOW;
      head         <= '0;
      count        <= '0;
      hold_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_SEQNO:  init_seqno   <= cfg_data;
          REG_INIT_WINDOW: window_bytes <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (ld) begin
        out_valid <= 1'b1;
        out_data  <= '{status: ld_status, out_seqno: ld_seq, out_len: ld_len,
                       last: ld_last, window_now: window_bytes, in_flight: flight_sat,
                       window_full: full, entries_used: 5'(count)};
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            k    <= '0;
            ptr  <= head;
            case (in_data.opcode)
              OP_ADD, OP_ACK: state <= S_UNWRAP;
              OP_TICK:        state <= S_TICK_RD;
              default:        state <= S_IDLE;
            endcase
          end
        end
        S_UNWRAP: begin
          abs_seq <= {uhi, off};
          state   <= (item.opcode == OP_ADD) ? S_ADD : S_ACK_CHK;
        end
        S_ADD: begin
          if (reject) begin
            emit_status <= ST_REJECTED;
          end else begin
            count       <= count + CW'(1);
            next_abs    <= abs_seq + {48'd0, item.seg_len};
            emit_status <= ST_ADDED;
          end
          state <= S_EMIT;
        end
        S_ACK_CHK: begin
          if (abs_seq > next_abs || abs_seq < first_abs || count == '0) begin
            emit_status <= ST_IGNORED;
            state       <= S_EMIT;
          end else begin
            k     <= count;
            ptr   <= (tail == '0) ? LAST_SLOT : tail - AW'(1);
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (abs_seq > rd.start) begin
            pop   <= k;
            state <= S_ACK_UPD;
          end else if (k == CW'(1)) begin
            pop   <= '0;
            state <= S_ACK_UPD;
          end else begin
            k     <= k - CW'(1);
            ptr   <= (ptr == '0) ? LAST_SLOT : ptr - AW'(1);
            state <= S_SRCH_RD;
          end
        end
        S_ACK_UPD: begin
          head         <= wrap_add(head, pop);
          count        <= count - pop;
          first_abs    <= abs_seq;
          window_bytes <= item.new_window;
          emit_status  <= ST_APPLIED;
          state        <= S_EMIT;
        end
        S_TICK_RD: begin
          state <= (k == count) ? S_TICK_END : S_TICK_CMP;
        end
        S_TICK_CMP: begin
          if (rd.timer > item.elapsed_ms || !hold_v || out_free) begin
            if (!(rd.timer > item.elapsed_ms)) begin
              hold_v   <= 1'b1;
              hold_seq <= rd.start[31:0] + init_seqno;
              hold_len <= rd.len;
            end
            k     <= k + CW'(1);
            ptr   <= (ptr == LAST_SLOT) ? '0 : ptr + AW'(1);
            state <= S_TICK_RD;
          end
        end
        S_TICK_END: begin
          if (out_free) begin
            hold_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

### hdl/rtwu_checker.sv
// Checker on the retransmit window unit ports, bound to the top level.
module rtwu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input rtwu_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rtwu_pkg::out_item_t out_data
);
  import rtwu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.opcode != OP_UNUSED) |=> in_stall)
    else $error("item accepted without going busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_NONE)
    else $error("bad status code");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_RETX) |-> out_data.last)
    else $error("single result beat without last");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.window_full |-> out_data.window_now != '0)
    else $error("zero window reported as not full");
endmodule

bind tcp_retransmit_window_unit rtwu_checker u_rtwu_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
